>>> rtl/bcmd_pkg.sv
// ----------------------------------------------------------------------------
// Button counter display package
// Shared widths, reset constants, result type and the seven-segment decoder.
// ----------------------------------------------------------------------------
package bcmd_pkg;

   localparam int NUM_DIGITS_DEFAULT = 4;
   localparam int THRESHOLD_WIDTH = 16;
   localparam int HOLD_WIDTH = 17;
   localparam int BCD_WIDTH = 4;
   localparam int ENABLE_WIDTH = 4;
   localparam int SEG_WIDTH = 7;
   localparam int COUNT_WIDTH = 14;

   localparam logic [THRESHOLD_WIDTH-1:0] HOLD_THRESHOLD_RESET = 16'd50000;
   localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = '1;
   localparam logic [BCD_WIDTH-1:0] BCD_NINE = 4'd9;

   localparam logic [SEG_WIDTH-1:0] SEG_0 = 7'b1111110;
   localparam logic [SEG_WIDTH-1:0] SEG_1 = 7'b0110000;
   localparam logic [SEG_WIDTH-1:0] SEG_2 = 7'b1101101;
   localparam logic [SEG_WIDTH-1:0] SEG_3 = 7'b1111001;
   localparam logic [SEG_WIDTH-1:0] SEG_4 = 7'b0110011;
   localparam logic [SEG_WIDTH-1:0] SEG_5 = 7'b1011011;
   localparam logic [SEG_WIDTH-1:0] SEG_6 = 7'b1011111;
   localparam logic [SEG_WIDTH-1:0] SEG_7 = 7'b1110000;
   localparam logic [SEG_WIDTH-1:0] SEG_8 = 7'b1111111;
   localparam logic [SEG_WIDTH-1:0] SEG_9 = 7'b1111011;
   localparam logic [SEG_WIDTH-1:0] SEG_OFF = 7'b0000000;

   typedef struct packed {
      logic [ENABLE_WIDTH-1:0] digit_enable_n;
      logic [SEG_WIDTH-1:0]    segments;
      logic [COUNT_WIDTH-1:0]  count_value;
   } rsp_type;

   function automatic logic [SEG_WIDTH-1:0] seg_decode(input logic [BCD_WIDTH-1:0] digit);
      logic [SEG_WIDTH-1:0] pattern;
      begin
         case (digit)
            4'd0: pattern = SEG_0;
            4'd1: pattern = SEG_1;
            4'd2: pattern = SEG_2;
            4'd3: pattern = SEG_3;
            4'd4: pattern = SEG_4;
            4'd5: pattern = SEG_5;
            4'd6: pattern = SEG_6;
            4'd7: pattern = SEG_7;
            4'd8: pattern = SEG_8;
            4'd9: pattern = SEG_9;
            default: pattern = SEG_OFF;
         endcase
         return pattern;
      end
   endfunction

endpackage

>>> rtl/button_counter_mux_display.sv
// The result of an accepted transaction is registered before it reaches the rsp_ port.
// One transaction per cycle unless req_stall; all state updates in the accepting cycle.
// req_stall rises only while two results wait for the rsp_ side (output plus skid entry).
// Reset clears the counters, digit position, segment latch, and result valids, and
// loads the hold threshold with 50000. csr_ready is always high.
// ----------------------------------------------------------------------------
// Button counter with multiplexed seven-segment display
// Counts long button presses in decimal and scans the digits onto a display.
// ----------------------------------------------------------------------------
module button_counter_mux_display #(
   parameter int NUM_DIGITS = bcmd_pkg::NUM_DIGITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_button_level,
   input  logic                                  req_scan_tick,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [bcmd_pkg::ENABLE_WIDTH-1:0]     rsp_digit_enable_n,
   output logic [bcmd_pkg::SEG_WIDTH-1:0]        rsp_segments,
   output logic [bcmd_pkg::COUNT_WIDTH-1:0]      rsp_count_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bcmd_pkg::THRESHOLD_WIDTH-1:0]  csr_hold_threshold
);
   import bcmd_pkg::*;

   localparam int POS_WIDTH = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam logic [POS_WIDTH-1:0] POS_LAST = POS_WIDTH'(NUM_DIGITS - 1);

   logic [THRESHOLD_WIDTH-1:0] threshold_ff;
   logic [HOLD_WIDTH-1:0]      hold_ff, hold_in, hold_inc;
   logic                       release_ff, release_in;
   logic [BCD_WIDTH-1:0]       digits_ff [NUM_DIGITS];
   logic [BCD_WIDTH-1:0]       digits_in [NUM_DIGITS];
   logic [NUM_DIGITS:0]        carry;
   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   logic [POS_WIDTH-1:0]       pos_ff, pos_in;
   logic [SEG_WIDTH-1:0]       seg_ff, seg_in;
   logic [ENABLE_WIDTH-1:0]    enable_n;
   logic                       bump;
   logic                       accept;
   logic                       out_take;
   rsp_type                    result;
   rsp_type                    out_ff, out_in;
   rsp_type                    skid_ff, skid_in;
   logic                       out_valid_ff, out_valid_in;
   logic                       skid_valid_ff, skid_valid_in;

   assign accept = req_valid && !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign out_take = out_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      hold_in = hold_ff;
      release_in = release_ff;
      bump = 1'b0;
      hold_inc = (hold_ff == HOLD_MAX) ? hold_ff : hold_ff + 1'b1;
      if (release_ff) begin
         if (!req_button_level) begin
            release_in = 1'b0;
            hold_in = '0;
         end
      end else if (req_button_level) begin
         hold_in = hold_inc;
         if (hold_inc > {1'b0, threshold_ff}) begin
            bump = 1'b1;
            release_in = 1'b1;
         end
      end
   end

   always_comb begin
      carry[0] = bump;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (carry[i]) begin
            digits_in[i] = (digits_ff[i] >= BCD_NINE) ? '0 : digits_ff[i] + 1'b1;
         end else begin
            digits_in[i] = digits_ff[i];
         end
         carry[i+1] = carry[i] && (digits_ff[i] >= BCD_NINE);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (bump) begin
         count_in = carry[NUM_DIGITS] ? '0 : count_ff + 1'b1;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      seg_in = seg_ff;
      if (req_scan_tick) begin
         pos_in = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
         seg_in = seg_decode(digits_in[pos_in]);
      end
   end

   always_comb begin
      for (int b = 0; b < ENABLE_WIDTH; b++) begin
         enable_n[b] = (b < NUM_DIGITS) && (int'(pos_in) != b);
      end
   end

   assign result.digit_enable_n = enable_n;
   assign result.segments = seg_in;
   assign result.count_value = count_in;

   always_comb begin
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      skid_in = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_in = skid_ff;
            out_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= HOLD_THRESHOLD_RESET;
         hold_ff <= '0;
         release_ff <= 1'b0;
         count_ff <= '0;
         pos_ff <= '0;
         seg_ff <= SEG_OFF;
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digits_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_hold_threshold;
         end
         if (accept) begin
            hold_ff <= hold_in;
            release_ff <= release_in;
            count_ff <= count_in;
            pos_ff <= pos_in;
            seg_ff <= seg_in;
            for (int i = 0; i < NUM_DIGITS; i++) begin
               digits_ff[i] <= digits_in[i];
            end
         end
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_digit_enable_n = out_ff.digit_enable_n;
   assign rsp_segments = out_ff.segments;
   assign rsp_count_value = out_ff.count_value;

   // A waiting skid entry always sits behind a held output entry.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without output entry");

   // Entering the release wait always comes with a count change.
   assert property (@(posedge clock) disable iff (reset)
      $rose(release_ff) |-> (count_ff != $past(count_ff)))
      else $error("release wait entered without a count increment");

   // At most one digit is enabled at a time.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones(~rsp_digit_enable_n) <= 1))
      else $error("more than one digit enabled");

endmodule

>>> sim/tb_button_counter_mux_display.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button counter display testbench
// Drives button and scan-tick samples through the request channel and checks
// every display frame against a local model of the press detector, the BCD
// counter and the digit scan, or against a directed row's frame. A directed
// table comes first, then random press runs under several hold thresholds.
// ----------------------------------------------------------------------------
module tb_button_counter_mux_display;
   import bcmd_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic [9:0][SEG_WIDTH-1:0] DIGIT_SEGS = {
      SEG_9, SEG_8, SEG_7, SEG_6, SEG_5, SEG_4, SEG_3, SEG_2, SEG_1, SEG_0
   };

   typedef enum logic {ROW_SAMPLE, ROW_THRESHOLD} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      logic                       pressed;
      logic                       tick;
      logic [THRESHOLD_WIDTH-1:0] threshold;
      bit                         typed;
      rsp_type                    frame;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_button_level = 1'b0;
   logic req_scan_tick = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ENABLE_WIDTH-1:0] rsp_digit_enable_n;
   logic [SEG_WIDTH-1:0] rsp_segments;
   logic [COUNT_WIDTH-1:0] rsp_count_value;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [THRESHOLD_WIDTH-1:0] csr_hold_threshold = '0;

   logic [THRESHOLD_WIDTH-1:0] hold_threshold;
   logic [HOLD_WIDTH-1:0] hold_count;
   logic release_wait;
   logic [BCD_WIDTH-1:0] bcd_digits [4];
   logic [1:0] digit_pos;
   logic [SEG_WIDTH-1:0] seg_latch;

   rsp_type frame_q [$];
   rsp_type want;
   int mismatches = 0;
   int cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int mode_left = 1;

   button_counter_mux_display dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_button_level   (req_button_level),
      .req_scan_tick      (req_scan_tick),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digit_enable_n (rsp_digit_enable_n),
      .rsp_segments       (rsp_segments),
      .rsp_count_value    (rsp_count_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_hold_threshold (csr_hold_threshold)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_button_counter_mux_display: errors");
         $finish;
      end
   end

   task automatic press_and_scan(input logic pressed, input logic tick,
                                 output rsp_type frame);
      int k;
      bit carry;
      begin
         if (release_wait) begin
            if (!pressed) begin
               release_wait = 1'b0;
               hold_count = '0;
            end
         end else if (pressed) begin
            if (hold_count != HOLD_MAX) hold_count++;
            if (hold_count > {1'b0, hold_threshold}) begin
               carry = 1'b1;
               for (k = 0; k < 4; k++) begin
                  if (carry) begin
                     if (bcd_digits[k] == BCD_NINE) begin
                        bcd_digits[k] = '0;
                     end else begin
                        bcd_digits[k]++;
                        carry = 1'b0;
                     end
                  end
               end
               release_wait = 1'b1;
            end
         end
         if (tick) begin
            digit_pos++;
            seg_latch = DIGIT_SEGS[bcd_digits[digit_pos]];
         end
         frame.digit_enable_n = ~(ENABLE_WIDTH'(1) << digit_pos);
         frame.segments = seg_latch;
         frame.count_value = COUNT_WIDTH'(bcd_digits[3] * 1000 + bcd_digits[2] * 100
                                          + bcd_digits[1] * 10 + bcd_digits[0]);
      end
   endtask

   task automatic offer(input logic pressed, input logic tick, input bit typed,
                        input rsp_type typed_frame);
      rsp_type frame;
      int gap;
      begin
         req_valid <= 1'b1;
         req_button_level <= pressed;
         req_scan_tick <= tick;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         press_and_scan(pressed, tick, frame);
         frame_q.push_back(typed ? typed_frame : frame);
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   task automatic set_threshold(input logic [THRESHOLD_WIDTH-1:0] value);
      begin
         req_valid <= 1'b0;
         while (frame_q.size() != 0) @(posedge clock);
         repeat (3) @(posedge clock);
         csr_valid <= 1'b1;
         csr_hold_threshold <= value;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         csr_valid <= 1'b0;
         hold_threshold = value;
      end
   endtask

   function automatic stim_row_type sample_row(input logic pressed, input logic tick);
      stim_row_type r;
      r.kind = ROW_SAMPLE;
      r.pressed = pressed;
      r.tick = tick;
      r.threshold = '0;
      r.typed = 1'b0;
      r.frame = '0;
      return r;
   endfunction

   function automatic stim_row_type known_row(input logic pressed, input logic tick,
                                              input logic [ENABLE_WIDTH-1:0] enable_n,
                                              input logic [SEG_WIDTH-1:0] segs,
                                              input int count);
      stim_row_type r;
      r = sample_row(pressed, tick);
      r.typed = 1'b1;
      r.frame.digit_enable_n = enable_n;
      r.frame.segments = segs;
      r.frame.count_value = COUNT_WIDTH'(count);
      return r;
   endfunction

   function automatic stim_row_type threshold_row(input logic [THRESHOLD_WIDTH-1:0] value);
      stim_row_type r;
      r = sample_row(1'b0, 1'b0);
      r.kind = ROW_THRESHOLD;
      r.threshold = value;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected frame: en=%b seg=%b count=%0d",
                           rsp_digit_enable_n, rsp_segments, rsp_count_value);
            end else begin
               want = frame_q.pop_front();
               if (rsp_digit_enable_n !== want.digit_enable_n
                   || rsp_segments !== want.segments
                   || rsp_count_value !== want.count_value) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("frame mismatch: expected en=%b seg=%b count=%0d",
                              want.digit_enable_n, want.segments, want.count_value);
                     $display("                got en=%b seg=%b count=%0d",
                              rsp_digit_enable_n, rsp_segments, rsp_count_value);
                  end
               end
            end
         end
         mode_left--;
         if (mode_left <= 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   initial begin
      stim_row_type directed [$];
      int p;
      int sent;
      int reach;
      int run;
      logic [THRESHOLD_WIDTH-1:0] phase_value;

      hold_threshold = HOLD_THRESHOLD_RESET;
      hold_count = '0;
      release_wait = 1'b0;
      for (p = 0; p < 4; p++) bcd_digits[p] = '0;
      digit_pos = '0;
      seg_latch = SEG_OFF;

      directed.push_back(known_row(1'b0, 1'b0, 4'b1110, SEG_OFF, 0));
      directed.push_back(sample_row(1'b1, 1'b0));
      directed.push_back(known_row(1'b1, 1'b1, 4'b1101, SEG_0, 0));
      directed.push_back(threshold_row(16'd1));
      directed.push_back(known_row(1'b1, 1'b0, 4'b1101, SEG_0, 1));
      directed.push_back(known_row(1'b1, 1'b1, 4'b1011, SEG_0, 1));
      directed.push_back(known_row(1'b0, 1'b0, 4'b1011, SEG_0, 1));
      directed.push_back(sample_row(1'b1, 1'b1));
      directed.push_back(known_row(1'b1, 1'b1, 4'b1110, SEG_2, 2));
      directed.push_back(threshold_row(16'd0));
      directed.push_back(sample_row(1'b0, 1'b0));
      directed.push_back(known_row(1'b1, 1'b0, 4'b1110, SEG_2, 3));
      directed.push_back(sample_row(1'b0, 1'b1));
      directed.push_back(threshold_row(16'hFFFF));
      directed.push_back(sample_row(1'b1, 1'b0));
      directed.push_back(sample_row(1'b1, 1'b1));
      directed.push_back(sample_row(1'b0, 1'b1));
      directed.push_back(sample_row(1'b1, 1'b0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_THRESHOLD)
            set_threshold(directed[i].threshold);
         else
            offer(directed[i].pressed, directed[i].tick, directed[i].typed,
                  directed[i].frame);
      end

      for (p = 0; p < 9; p++) begin
         case (p)
            0: phase_value = 16'd2;
            1: phase_value = 16'd0;
            2: phase_value = 16'($urandom_range(3, 7));
            3: phase_value = 16'hFFFF;
            4: phase_value = 16'd1;
            5: phase_value = 16'($urandom_range(0, 16'hFFFF));
            6: phase_value = 16'($urandom_range(0, 4));
            7: phase_value = 16'd0;
            default: phase_value = 16'd3;
         endcase
         set_threshold(phase_value);
         reach = (hold_threshold < 8) ? hold_threshold + 1 : 8;
         sent = 0;
         while (sent < 68) begin
            if ($urandom_range(0, 4) != 0) begin
               run = $urandom_range(1, reach + 1);
               repeat (run) offer(1'b1, 1'($urandom_range(0, 1)), 1'b0, '0);
               sent += run;
               run = $urandom_range(1, 3);
               repeat (run) offer(1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
               sent += run;
            end else begin
               run = $urandom_range(1, 4);
               repeat (run) offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'b0, '0);
               sent += run;
            end
         end
      end

      req_valid <= 1'b0;
      while (frame_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0 && frame_q.size() == 0) begin
         $display("tb_button_counter_mux_display: clean");
      end else begin
         $display("tb_button_counter_mux_display: errors");
      end
      $finish;
   end

endmodule

>>> button_counter_mux_display.f
rtl/bcmd_pkg.sv
rtl/button_counter_mux_display.sv
sim/tb_button_counter_mux_display.sv
